[sv/cmf_pkg.sv]
// cmf_pkg: shared constants, types and the median helper for the clipped 3x3 median filter
// used by cmf_window and clipped_median_filter_3x3; no dependencies
`timescale 1ns / 1ps

package cmf_pkg;

  localparam int unsigned MaxWidthDef = 64;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned WinRows = 3;
  localparam int unsigned PixW = 8;
  localparam int unsigned RowW = 12;
  localparam int unsigned ColOutW = 6;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned WidthRegW = 7;
  localparam int unsigned HeightRegW = 13;
  localparam logic [CfgIdxW-1:0] RegImageWidth = 1'b0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 1'b1;

  typedef logic [PixW-1:0] pix_t;

  // one result request travelling down the pipe
  typedef struct packed {
    logic [RowW-1:0] row;
    logic [10:0]     col;
    logic [1:0]      slot_up;
    logic [1:0]      slot_mid;
    logic [1:0]      slot_dn;
    logic            has_up;
    logic            has_dn;
    logic            has_lf;
    logic            has_rt;
    logic            fend;
    logic            last;
  } req_t;

  function automatic pix_t mid3(input pix_t a, input pix_t b, input pix_t c);
    pix_t lo;
    pix_t hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) return lo;
    if (c >= hi) return hi;
    return c;
  endfunction

endpackage

[sv/cmf_window.sv]
// cmf_window: median of a clipped window of up to nine pixels, two pipeline stages
// depends on cmf_pkg
`timescale 1ns / 1ps

module cmf_window import cmf_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  pix_t [8:0]       win_i,
  input  logic [8:0]       msk_i,
  output pix_t             med_o
);

  localparam int unsigned NumW = 9;
  logic [3:0] rank_q [NumW];
  logic [3:0] cnt_q;
  pix_t       val_q [NumW];
  pix_t       lo;
  pix_t       hi;

  // stage 1: rank of each valid entry (ties broken by index)
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cnt_q <= 4'($countones(msk_i));
      for (int i = 0; i < NumW; i++) begin
        logic [3:0] r;
        r = '0;
        for (int j = 0; j < NumW; j++) begin
          if (msk_i[j] && j != i &&
              ((win_i[j] < win_i[i]) || (win_i[j] == win_i[i] && j < i))) begin
            r = r + 4'd1;
          end
        end
        rank_q[i] <= msk_i[i] ? r : 4'hf;
        val_q[i]  <= win_i[i];
      end
    end
  end

  // stage 2: pick the middle pair
  always_comb begin
    logic [3:0] k;
    logic [3:0] km;
    k  = cnt_q >> 1;
    km = cnt_q[0] ? k : k - 4'd1;
    lo = '0;
    hi = '0;
    for (int i = 0; i < NumW; i++) begin
      if (rank_q[i] == km) lo = val_q[i];
      if (rank_q[i] == k)  hi = val_q[i];
    end
  end

  logic [PixW:0] sum;
  assign sum   = {1'b0, lo} + {1'b0, hi};
  assign med_o = sum[PixW:1];

endmodule

[sv/clipped_median_filter_3x3.sv]
// clipped_median_filter_3x3: top level, line store memory, result scheduler and output skid
// depends on cmf_pkg and cmf_window
//
// Usage: pixels enter in raster order on pixel_i with in_valid_i / in_stall_o.
// Each pixel causes zero to four results on the output channel (filtered_o,
// out_row_o, out_col_o, frame_end_o, last_of_run_o) with out_valid_o / out_stall_i.
// One request is issued per cycle while the skid and pipeline have room. In row 0
// and at column 0 a pixel issues no request, at interior columns of a middle row one;
// the last column of a middle row issues two. In the last row every pixel from column 1
// on issues two requests and the last column issues four.
// The first request of a pixel issues in the cycle it is accepted; its result
// passes the line store read, the rank stage and the skid write before it can
// be taken.
// out_stall_i is absorbed by a four-entry output skid; in_stall_o is high while
// extra requests of a pixel are pending or while the skid and the two pipeline
// stages together hold four results.
// Reset clears control state and sets image width and height to 64; the line
// store needs no clearing, windows never reach unwritten entries.
// A configuration write restarts the frame at row 0, column 0.
`timescale 1ns / 1ps

module clipped_median_filter_3x3 import cmf_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PixW-1:0]       pixel_i,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PixW-1:0]       filtered_o,
  output logic [RowW-1:0]       out_row_o,
  output logic [ColOutW-1:0]    out_col_o,
  output logic                  frame_end_o,
  output logic                  last_of_run_o
);

  localparam int unsigned ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CntW = $clog2(MAX_WIDTH + 1);

  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;
  logic [CntW-1:0]       w_eff;
  logic [RowW-1:0]       h_m1;

  always_comb begin
    if (width_q < WidthRegW'(2)) w_eff = CntW'(2);
    else if (32'(width_q) > MAX_WIDTH) w_eff = CntW'(MAX_WIDTH);
    else w_eff = CntW'(width_q);
    if (height_q < HeightRegW'(2)) h_m1 = RowW'(1);
    else if (height_q > HeightRegW'(MaxHeight)) h_m1 = RowW'(MaxHeight - 1);
    else h_m1 = RowW'(height_q - HeightRegW'(1));
  end

  // frame position and pending extra requests
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [1:0]      slot_q, slot_d;
  logic [3:0]      pend_q, pend_d;
  logic [RowW-1:0] pr_q;
  logic [ColW-1:0] pc_q;
  logic [1:0]      ps_q;
  logic            advance;
  logic            accept;

  // skid occupancy and pipeline valid bits
  logic [1:0] v_q;
  logic [2:0] skid_cnt;
  logic [2:0] inflight;
  logic       room;

  assign inflight = 3'(v_q[0]) + 3'(v_q[1]);
  assign room     = (skid_cnt + inflight) < 3'd4;
  assign in_stall_o = !(room && pend_q == 4'd0);
  assign accept     = in_valid_i && !in_stall_o;

  // request generation
  req_t       req;
  logic       req_v;
  logic [3:0] sched;
  logic       lastc;

  function automatic logic [1:0] sdec(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction
  function automatic logic [1:0] sinc(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic req_t mkreq(input logic [RowW-1:0] r, input logic [ColW-1:0] c,
                                 input logic [1:0] s, input logic [CntW-1:0] w,
                                 input logic [RowW-1:0] hm1, input logic lst);
    req_t q;
    q.row = r;
    q.col = 11'(c);
    q.slot_mid = s;
    q.slot_up = sdec(s);
    q.slot_dn = sinc(s);
    q.has_up = (r != '0);
    q.has_dn = (r != hm1);
    q.has_lf = (c != '0);
    q.has_rt = (CntW'(c) != w - CntW'(1));
    q.fend = (r == hm1) && (CntW'(c) == w - CntW'(1));
    q.last = lst;
    return q;
  endfunction

  // sched bits: 0 (R-1,C-1), 1 (R-1,C), 2 (R,C-1), 3 (R,C)
  always_comb begin
    lastc = (CntW'(col_q) == w_eff - CntW'(1));
    sched[0] = (row_q != '0) && (col_q != '0);
    sched[1] = (row_q != '0) && lastc;
    sched[2] = (row_q == h_m1) && (col_q != '0);
    sched[3] = (row_q == h_m1) && lastc;
  end

  logic [3:0] cur;
  logic [1:0] sel;
  logic [3:0] rest;
  always_comb begin
    cur = accept ? sched : pend_q;
    sel = 2'd0;
    for (int i = 3; i >= 0; i--) if (cur[i]) sel = 2'(i);
    rest = cur;
    rest[sel] = 1'b0;
    req_v = (cur != 4'd0) && (accept || room);
    req = '0;
    begin
      logic [RowW-1:0] rr;
      logic [ColW-1:0] cc;
      logic [1:0]      ss;
      logic [RowW-1:0] br;
      logic [ColW-1:0] bc;
      logic [1:0]      bs;
      br = accept ? row_q : pr_q;
      bc = accept ? col_q : pc_q;
      bs = accept ? slot_q : ps_q;
      rr = sel[1] ? br : br - RowW'(1);
      ss = sel[1] ? bs : sdec(bs);
      if (sel == 2'd0 || sel == 2'd2) cc = bc - ColW'(1);
      else cc = bc;
      req = mkreq(rr, cc, ss, w_eff, h_m1, rest == 4'd0);
    end
    pend_d = req_v ? rest : pend_q;
  end

  assign advance = accept;
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    slot_d = slot_q;
    if (advance) begin
      if (CntW'(col_q) == w_eff - CntW'(1)) begin
        col_d = '0;
        if (row_q == h_m1) begin
          row_d = '0;
          slot_d = 2'd0;
        end else begin
          row_d = row_q + RowW'(1);
          slot_d = sinc(slot_q);
        end
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRegW'(64);
      height_q <= HeightRegW'(64);
      col_q    <= '0;
      row_q    <= '0;
      slot_q   <= '0;
      pend_q   <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
      pend_q <= pend_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegImageWidth) width_q <= cfg_data_i[WidthRegW-1:0];
        if (cfg_idx_i == RegImageHeight) height_q <= cfg_data_i[HeightRegW-1:0];
        col_q  <= '0;
        row_q  <= '0;
        slot_q <= '0;
        pend_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pr_q <= row_q;
      pc_q <= col_q;
      ps_q <= slot_q;
    end
  end

  // line store: one bank per row slot, each replicated per column phase
  // (left, mid, right), so every array sees one read and one write a cycle
  localparam int unsigned AW = 2 + ColW;

  function automatic logic [AW-1:0] addr(input logic [1:0] s, input logic [ColW-1:0] c);
    return {s, c};
  endfunction

  logic [ColW-1:0] cl, cr;
  assign cl = req.has_lf ? req.col[ColW-1:0] - ColW'(1) : req.col[ColW-1:0];
  assign cr = req.has_rt ? req.col[ColW-1:0] + ColW'(1) : req.col[ColW-1:0];

  logic [ColW-1:0] rcol [3];
  assign rcol[0] = cl;
  assign rcol[1] = req.col[ColW-1:0];
  assign rcol[2] = cr;

  // write is a single port, so reads of entries written in the read cycle are forwarded
  pix_t rd_q [3][3];
  logic [AW-1:0] wa;
  assign wa = addr(slot_q, col_q);
  req_t r1_q;
  logic [AW-1:0] wa_q;
  pix_t wd_q;
  logic wv_q;

  for (genvar b = 0; b < 3; b++) begin : g_bank
    for (genvar x = 0; x < 3; x++) begin : g_copy
      pix_t mem [MAX_WIDTH];
      always_ff @(posedge clk_i) begin
        if (accept && slot_q == 2'(b)) mem[col_q] <= pixel_i;
        if (req_v) rd_q[b][x] <= mem[rcol[x]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_v) begin
      r1_q <= req;
      wa_q <= wa;
      wd_q <= pixel_i;
      wv_q <= accept;
    end
  end

  // window assembly with forwarding of the pixel written in the read cycle
  pix_t [8:0] win;
  logic [8:0] msk;
  logic [AW-1:0] ra [3][3];
  always_comb begin
    logic [ColW-1:0] c0, c1, c2;
    logic [1:0] sl [3];
    c1 = r1_q.col[ColW-1:0];
    c0 = r1_q.has_lf ? c1 - ColW'(1) : c1;
    c2 = r1_q.has_rt ? c1 + ColW'(1) : c1;
    sl[0] = r1_q.slot_up;
    sl[1] = r1_q.slot_mid;
    sl[2] = r1_q.slot_dn;
    for (int y = 0; y < 3; y++) begin
      ra[y][0] = addr(sl[y], c0);
      ra[y][1] = addr(sl[y], c1);
      ra[y][2] = addr(sl[y], c2);
      for (int x = 0; x < 3; x++) begin
        win[y*3+x] = (wv_q && wa_q == ra[y][x]) ? wd_q : rd_q[sl[y]][x];
      end
    end
    msk[0] = r1_q.has_up && r1_q.has_lf;
    msk[1] = r1_q.has_up;
    msk[2] = r1_q.has_up && r1_q.has_rt;
    msk[3] = r1_q.has_lf;
    msk[4] = 1'b1;
    msk[5] = r1_q.has_rt;
    msk[6] = r1_q.has_dn && r1_q.has_lf;
    msk[7] = r1_q.has_dn;
    msk[8] = r1_q.has_dn && r1_q.has_rt;
  end

  pix_t med;
  req_t r2_q, r3_q;
  logic step;
  assign step = 1'b1;

  cmf_window u_win (
    .clk_i (clk_i),
    .en_i  (step),
    .win_i (win),
    .msk_i (msk),
    .med_o (med)
  );

  always_ff @(posedge clk_i) begin
    r2_q <= r1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[0], req_v};
    end
  end

  // four-entry output skid
  pix_t       sk_med [4];
  req_t       sk_req [4];
  logic [1:0] rp_q, wp_q;
  logic [2:0] cnt_q;
  logic       push, pop;

  assign push = v_q[1];
  assign pop  = out_valid_o && !out_stall_i;
  assign skid_cnt = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push) begin
      sk_med[wp_q] <= med;
      sk_req[wp_q] <= r2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q  <= '0;
      wp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 2'd1;
      if (pop)  rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'(push) - 3'(pop);
    end
  end

  assign r3_q          = sk_req[rp_q];
  assign out_valid_o   = cnt_q != 3'd0;
  assign filtered_o    = sk_med[rp_q];
  assign out_row_o     = r3_q.row;
  assign out_col_o     = r3_q.col[ColOutW-1:0];
  assign frame_end_o   = r3_q.fend;
  assign last_of_run_o = r3_q.last;

`ifndef ASSERT_OFF
  a_skid_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("skid overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 3'd4 && !pop) |-> !push) else $error("push into full skid");
  a_pend_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != 4'd0) |-> !accept) else $error("pixel taken during run");
  a_mid_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> $past(req_v, 2)) else $error("pipeline valid broken");
`endif

endmodule

[verif/tb_top.sv]
// tb_top: self-checking testbench for clipped_median_filter_3x3
// a built-in predictor of the clipped median checks every result; needs cmf_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;
  import cmf_pkg::*;

  typedef struct {
    logic [PixW-1:0]    filtered;
    logic [RowW-1:0]    row;
    logic [ColOutW-1:0] col;
    logic               fend;
    logic               last;
  } median_res_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [PixW-1:0]     pixel_i = '0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = RegImageWidth;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [PixW-1:0]     filtered_o;
  logic [RowW-1:0]     out_row_o;
  logic [ColOutW-1:0]  out_col_o;
  logic                frame_end_o;
  logic                last_of_run_o;

  clipped_median_filter_3x3 u_top (.*);

  // predictor state
  logic [PixW-1:0] lines_q [3][64];
  int unsigned     pred_col, pred_row, width_reg, height_reg;
  median_res_t     medians_q[$];
  int unsigned     mismatches, pixels_sent, results_seen, burst_left;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic int unsigned eff_w();
    if (width_reg < 2) return 2;
    if (width_reg > 64) return 64;
    return width_reg;
  endfunction

  function automatic int unsigned eff_h();
    if (height_reg < 2) return 2;
    if (height_reg > MaxHeight) return MaxHeight;
    return height_reg;
  endfunction

  function automatic logic [PixW-1:0] clipped_median(int unsigned r, int unsigned c,
                                                      int unsigned w, int unsigned h);
    int unsigned vals[9];
    int unsigned n, j, v, r0, r1, c0, c1;
    n = 0;
    r0 = (r > 0) ? r - 1 : 0;
    r1 = (r + 1 < h) ? r + 1 : h - 1;
    c0 = (c > 0) ? c - 1 : 0;
    c1 = (c + 1 < w) ? c + 1 : w - 1;
    for (int unsigned y = r0; y <= r1; y++) begin
      for (int unsigned x = c0; x <= c1; x++) begin
        v = lines_q[y % 3][x];
        j = n;
        while (j > 0 && vals[j-1] > v) begin
          vals[j] = vals[j-1];
          j--;
        end
        vals[j] = v;
        n++;
      end
    end
    if (n % 2 == 0) return PixW'((vals[n/2-1] + vals[n/2]) / 2);
    return PixW'(vals[n/2]);
  endfunction

  function automatic void push_median(int unsigned r, int unsigned c, int unsigned w,
                                      int unsigned h);
    median_res_t m;
    m.filtered = clipped_median(r, c, w, h);
    m.row = r[RowW-1:0];
    m.col = c[ColOutW-1:0];
    m.fend = (r == h - 1 && c == w - 1);
    m.last = 1'b0;
    medians_q.push_back(m);
  endfunction

  function automatic void predict_pixel(logic [PixW-1:0] p);
    int unsigned w, h, r, c, n0;
    w = eff_w();
    h = eff_h();
    r = pred_row;
    c = pred_col;
    n0 = medians_q.size();
    lines_q[r % 3][c] = p;
    if (r >= 1) begin
      if (c >= 1) push_median(r - 1, c - 1, w, h);
      if (c == w - 1) push_median(r - 1, c, w, h);
    end
    if (r == h - 1) begin
      if (c >= 1) push_median(r, c - 1, w, h);
      if (c == w - 1) push_median(r, c, w, h);
    end
    if (medians_q.size() > n0) medians_q[medians_q.size()-1].last = 1'b1;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    pred_col = c;
    pred_row = r;
  endfunction

  // result checker
  always @(negedge clk_i) begin
    median_res_t m;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (medians_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result row %0d col %0d", out_row_o, out_col_o);
      end else begin
        m = medians_q.pop_front();
        if (m.filtered !== filtered_o || m.row !== out_row_o || m.col !== out_col_o ||
            m.fend !== frame_end_o || m.last !== last_of_run_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d r%0d c%0d fe%0b l%0b got %0d r%0d c%0d fe%0b l%0b",
                     m.filtered, m.row, m.col, m.fend, m.last,
                     filtered_o, out_row_o, out_col_o, frame_end_o, last_of_run_o);
        end
      end
    end
  end

  // receiver stall pattern
  int unsigned stall_mode, stall_left;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(5, 60);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 9) < 3);
      2: out_stall_i <= ($urandom_range(0, 9) < 8);
      default: out_stall_i <= (stall_left % 4 == 0);
    endcase
  end

  task automatic send_pixel(logic [PixW-1:0] p);
    logic taken;
    in_valid_i <= 1'b1;
    pixel_i <= p;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    predict_pixel(p);
    pixels_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (medians_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegImageWidth) width_reg = val & 32'h7f;
    else height_reg = val & 32'h1fff;
    pred_col = 0;
    pred_row = 0;
  endtask

  task automatic send_frame(int unsigned count, bit extremes);
    for (int unsigned i = 0; i < count; i++) begin
      if (extremes) send_pixel(($urandom_range(0, 1) != 0) ? 8'hff : 8'h00);
      else send_pixel(PixW'($urandom_range(0, 255)));
      if (i == count / 2 && $urandom_range(0, 3) == 0) drain();
    end
  endtask

  task automatic test_corners();
    write_reg(RegImageWidth, 2);
    write_reg(RegImageHeight, 2);
    send_pixel(8'h00);
    send_pixel(8'hff);
    send_pixel(8'hff);
    send_pixel(8'h00);
    // sizes below range act as two
    write_reg(RegImageWidth, 0);
    write_reg(RegImageHeight, 1);
    send_frame(4, 1'b1);
    write_reg(RegImageWidth, 1);
    write_reg(RegImageHeight, 0);
    send_frame(4, 1'b0);
    write_reg(RegImageWidth, 3);
    write_reg(RegImageHeight, 3);
    send_frame(9, 1'b1);
  endtask

  task automatic test_extreme_sizes();
    write_reg(RegImageWidth, 127);
    write_reg(RegImageHeight, 2);
    send_frame(128, 1'b0);
    write_reg(RegImageWidth, 64);
    write_reg(RegImageHeight, 3);
    send_frame(40, 1'b0);
    // partial frames at the tallest heights, then restart
    write_reg(RegImageWidth, 2);
    write_reg(RegImageHeight, 4096);
    send_frame(10, 1'b0);
    write_reg(RegImageHeight, 8191);
    send_frame(10, 1'b0);
    write_reg(RegImageHeight, 4097);
    send_frame(6, 1'b0);
  endtask

  task automatic test_random_frames();
    int unsigned w, h, n;
    while (pixels_sent < 470) begin
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 9);
      h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
      write_reg(RegImageWidth, w);
      write_reg(RegImageHeight, h);
      n = eff_w() * eff_h();
      if (n > 60) n = 60;
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      if (n > 470 - pixels_sent) n = 470 - pixels_sent;
      send_frame(n, 1'b0);
    end
  endtask

  initial begin
    width_reg = 64;
    height_reg = 64;
    pred_col = 0;
    pred_row = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    test_extreme_sizes();
    test_random_frames();
    drain();
    repeat (20) @(posedge clk_i);
    $display("covered %0d pixels and %0d filtered results over corner, edge,", pixels_sent,
             results_seen);
    $display("out-of-range size and random frame sizes, %0d mismatches", mismatches);
    if (mismatches == 0 && medians_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
sv/cmf_pkg.sv
sv/cmf_window.sv
sv/clipped_median_filter_3x3.sv
verif/tb_top.sv
